@@ src/ufmc_pkg.sv @@
// Shared types and constants for the union-find spanning tree cost block.
`timescale 1ns / 1ps
`default_nettype none

package ufmc_pkg;

  localparam int VERTICES = 1024;
  localparam int VTX_W    = $clog2(VERTICES);
  localparam int VIN_W    = 10;
  localparam int WGT_W    = 16;
  localparam int COST_W   = 32;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_FIND1,
    ST_HALF1,
    ST_FIND2,
    ST_HALF2,
    ST_LINK,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    RD_A,
    RD_B,
    RD_DATA
  } rd_src_e;

  typedef struct packed {
    logic    cap;
    logic    clr_cost;
    logic    sweep;
    logic    root1;
    logic    halve;
    logic    link;
    rd_src_e rd_src;
  } ctrl_t;

  typedef struct packed {
    logic in_range;
    logic at_root;
    logic same_root;
    logic sweep_last;
  } stat_t;

endpackage

`default_nettype wire

@@ src/ufmc_datapath.sv @@
// Datapath: parent memory, vertex walk registers, sweep counter and cost accumulator.
`timescale 1ns / 1ps
`default_nettype none

module ufmc_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ufmc_pkg::ctrl_t             ctrl_i,
  output ufmc_pkg::stat_t                  stat_o,
  input  wire logic [ufmc_pkg::VIN_W-1:0]  first_vertex_i,
  input  wire logic [ufmc_pkg::VIN_W-1:0]  second_vertex_i,
  input  wire logic [ufmc_pkg::WGT_W-1:0]  edge_weight_i,
  output logic                             merged_o,
  output logic [ufmc_pkg::COST_W-1:0]      total_cost_o,
  output logic                             cost_saturated_o
);

  logic [ufmc_pkg::VTX_W-1:0] mem [ufmc_pkg::VERTICES];

  logic [ufmc_pkg::VTX_W-1:0]  v_q, b_q, root1_q, cnt_q, rd_data_q;
  logic [ufmc_pkg::WGT_W-1:0]  w_q;
  logic [ufmc_pkg::COST_W-1:0] cost_q, cost_d;
  logic                        sat_q, sat_d, merged_q, merged_d;

  logic [ufmc_pkg::VTX_W-1:0]  rd_addr, wr_addr, wr_data;
  logic                        wr_en;
  logic [ufmc_pkg::COST_W:0]   sum;

  always_comb begin
    case (ctrl_i.rd_src)
      ufmc_pkg::RD_A:    rd_addr = ufmc_pkg::VTX_W'(first_vertex_i);
      ufmc_pkg::RD_B:    rd_addr = b_q;
      ufmc_pkg::RD_DATA: rd_addr = rd_data_q;
      default:           rd_addr = rd_data_q;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = v_q;
    wr_data = rd_data_q;
    if (ctrl_i.sweep) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q;
      wr_data = cnt_q;
    end else if (ctrl_i.halve) begin
      wr_en   = 1'b1;
    end else if (ctrl_i.link) begin
      wr_en   = 1'b1;
      wr_data = root1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      v_q <= ufmc_pkg::VTX_W'(first_vertex_i);
      b_q <= ufmc_pkg::VTX_W'(second_vertex_i);
      w_q <= edge_weight_i;
    end else if (ctrl_i.root1) begin
      root1_q <= v_q;
      v_q     <= b_q;
    end else if (ctrl_i.halve) begin
      v_q <= rd_data_q;
    end
  end

  // The sweep counter starts at zero after reset and after each clear command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.clr_cost) begin
      cnt_q <= '0;
    end else if (ctrl_i.sweep) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign sum = {1'b0, cost_q} + (ufmc_pkg::COST_W + 1)'(w_q);

  always_comb begin
    cost_d   = cost_q;
    sat_d    = sat_q;
    merged_d = merged_q;
    if (ctrl_i.cap) begin
      merged_d = 1'b0;
    end
    if (ctrl_i.clr_cost) begin
      cost_d = '0;
      sat_d  = 1'b0;
    end
    if (ctrl_i.link) begin
      merged_d = 1'b1;
      if (sum >= {1'b0, ufmc_pkg::COST_MAX}) begin
        cost_d = ufmc_pkg::COST_MAX;
        sat_d  = 1'b1;
      end else begin
        cost_d = sum[ufmc_pkg::COST_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q   <= '0;
      sat_q    <= 1'b0;
      merged_q <= 1'b0;
    end else begin
      cost_q   <= cost_d;
      sat_q    <= sat_d;
      merged_q <= merged_d;
    end
  end

  assign stat_o.in_range   = (32'(first_vertex_i) < 32'(ufmc_pkg::VERTICES)) &&
                             (32'(second_vertex_i) < 32'(ufmc_pkg::VERTICES));
  assign stat_o.at_root    = (rd_data_q == v_q);
  assign stat_o.same_root  = (root1_q == v_q);
  assign stat_o.sweep_last = (cnt_q == ufmc_pkg::VTX_W'(ufmc_pkg::VERTICES - 1));

  assign merged_o         = merged_q;
  assign total_cost_o     = cost_q;
  assign cost_saturated_o = sat_q;

endmodule

`default_nettype wire

@@ src/ufmc_ctrl.sv @@
// Controller state machine: sequences the sweep, both root walks and the link.
`timescale 1ns / 1ps
`default_nettype none

module ufmc_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            command_i,
  input  wire ufmc_pkg::stat_t stat_i,
  output ufmc_pkg::ctrl_t      ctrl_o,
  output logic                 busy_o,
  output logic                 done_o
);

  ufmc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ufmc_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ufmc_pkg::ST_INIT: begin
        if (stat_i.sweep_last) state_d = ufmc_pkg::ST_IDLE;
      end
      ufmc_pkg::ST_IDLE: begin
        if (start_i) begin
          if (command_i)             state_d = ufmc_pkg::ST_CLEAR;
          else if (!stat_i.in_range) state_d = ufmc_pkg::ST_DONE;
          else                       state_d = ufmc_pkg::ST_FIND1;
        end
      end
      ufmc_pkg::ST_CLEAR: begin
        if (stat_i.sweep_last) state_d = ufmc_pkg::ST_DONE;
      end
      ufmc_pkg::ST_FIND1: begin
        state_d = stat_i.at_root ? ufmc_pkg::ST_FIND2 : ufmc_pkg::ST_HALF1;
      end
      ufmc_pkg::ST_HALF1: state_d = ufmc_pkg::ST_FIND1;
      ufmc_pkg::ST_FIND2: begin
        if (!stat_i.at_root)       state_d = ufmc_pkg::ST_HALF2;
        else if (stat_i.same_root) state_d = ufmc_pkg::ST_DONE;
        else                       state_d = ufmc_pkg::ST_LINK;
      end
      ufmc_pkg::ST_HALF2: state_d = ufmc_pkg::ST_FIND2;
      ufmc_pkg::ST_LINK:  state_d = ufmc_pkg::ST_DONE;
      ufmc_pkg::ST_DONE:  state_d = ufmc_pkg::ST_IDLE;
      default:            state_d = ufmc_pkg::ST_INIT;
    endcase
  end

  // The read address normally follows the word just read, which walks the chain.
  always_comb begin
    ctrl_o = '{cap: 1'b0, clr_cost: 1'b0, sweep: 1'b0, root1: 1'b0,
               halve: 1'b0, link: 1'b0, rd_src: ufmc_pkg::RD_DATA};
    unique case (state_q)
      ufmc_pkg::ST_INIT:  ctrl_o.sweep = 1'b1;
      ufmc_pkg::ST_IDLE: begin
        ctrl_o.rd_src   = ufmc_pkg::RD_A;
        ctrl_o.cap      = start_i;
        ctrl_o.clr_cost = start_i & command_i;
      end
      ufmc_pkg::ST_CLEAR: ctrl_o.sweep = 1'b1;
      ufmc_pkg::ST_FIND1: begin
        if (stat_i.at_root) begin
          ctrl_o.root1  = 1'b1;
          ctrl_o.rd_src = ufmc_pkg::RD_B;
        end
      end
      ufmc_pkg::ST_HALF1: ctrl_o.halve = 1'b1;
      ufmc_pkg::ST_FIND2: ;
      ufmc_pkg::ST_HALF2: ctrl_o.halve = 1'b1;
      ufmc_pkg::ST_LINK:  ctrl_o.link  = 1'b1;
      ufmc_pkg::ST_DONE:  ;
      default:            ;
    endcase
  end

  assign busy_o = (state_q != ufmc_pkg::ST_IDLE);
  assign done_o = (state_q == ufmc_pkg::ST_DONE);

endmodule

`default_nettype wire

@@ src/union_find_mst_cost_top.sv @@
// Top level of the union-find spanning tree cost block.
//
// Usage: a word is accepted at a rising edge where start_i is high and busy_o
// is low. command_i = 0 processes the edge (first_vertex_i, second_vertex_i,
// edge_weight_i); command_i = 1 clears the forest and the running cost.
// Each word yields exactly one result, shown for one cycle while done_o is
// high: merged_o, total_cost_o and cost_saturated_o.
// An accepted edge walks FIND1/HALF1 to the first root and FIND2/HALF2 to the
// second, passes through LINK when the edge links two trees, and ends in DONE.
// Each non-root vertex visited on the two root walks costs one FIND and one
// HALF state, since every step of the walk waits on the registered read of the
// parent memory, and the next word is taken only after done_o.
// An edge with an endpoint out of range goes straight from IDLE to DONE.
// A clear command rewrites all 1024 parent entries, one per cycle, and then
// reports in DONE.
// After reset the same pass over all 1024 entries initializes the parent memory
// while busy_o stays high; no result is produced for it.
// The receiver cannot stall: every result is taken in its strobe cycle.
`timescale 1ns / 1ps
`default_nettype none

module union_find_mst_cost_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic                        command_i,
  input  wire logic [ufmc_pkg::VIN_W-1:0]  first_vertex_i,
  input  wire logic [ufmc_pkg::VIN_W-1:0]  second_vertex_i,
  input  wire logic [ufmc_pkg::WGT_W-1:0]  edge_weight_i,
  output logic                             done_o,
  output logic                             merged_o,
  output logic [ufmc_pkg::COST_W-1:0]      total_cost_o,
  output logic                             cost_saturated_o
);

  ufmc_pkg::ctrl_t ctrl;
  ufmc_pkg::stat_t stat;

  ufmc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .busy_o    (busy_o),
    .done_o    (done_o)
  );

  ufmc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .first_vertex_i   (first_vertex_i),
    .second_vertex_i  (second_vertex_i),
    .edge_weight_i    (edge_weight_i),
    .merged_o         (merged_o),
    .total_cost_o     (total_cost_o),
    .cost_saturated_o (cost_saturated_o)
  );

endmodule

`default_nettype wire
